// ===== rtl/sha1s_pkg.sv =====
// Shared types and constants for the SHA-1 byte stream hasher.
// No dependencies; imported by the round core and the top level.
package sha1s_pkg;

    typedef logic [31:0] t_word;

    // Five 32-bit words; index 0 is H0 (or working variable a).
    typedef logic [4:0][31:0] t_chain;

    // Status that the round core reports to the sequencer.
    typedef struct packed {
        logic busy;
        logic step;
        logic done;
    } t_cmp_stat;

    localparam t_chain H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                 32'hEFCDAB89, 32'h67452301};

    localparam t_word K_PH0 = 32'h5A827999;
    localparam t_word K_PH1 = 32'h6ED9EBA1;
    localparam t_word K_PH2 = 32'h8F1BBCDC;
    localparam t_word K_PH3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE    = 8'h80;
    localparam logic [5:0] FILL_LEN_AT = 6'd56;
    localparam logic [2:0] LAST_IDX    = 3'd4;
    localparam logic [6:0] ROUND_LAST  = 7'd79;

endpackage

// ===== rtl/sha1s_round_core.sv =====
// Iterative SHA-1 compression: one round per cycle over the working variables.
// Depends on sha1s_pkg; the schedule word comes from the caller's block register.
module sha1s_round_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  sha1s_pkg::t_chain  i_chain,
    input  sha1s_pkg::t_word   i_w,
    output sha1s_pkg::t_cmp_stat o_stat,
    output sha1s_pkg::t_chain  o_work
);
    import sha1s_pkg::*;

    t_chain     r_work;
    t_chain     n_work;
    logic [6:0] r_round;
    logic [6:0] n_round;
    logic       r_busy;
    logic       n_busy;
    logic       r_done;
    logic       n_done;

    t_word w_a;
    t_word w_b;
    t_word w_c;
    t_word w_d;
    t_word w_e;
    t_word w_f;
    t_word w_k;
    t_word w_t;

    assign w_a = r_work[0];
    assign w_b = r_work[1];
    assign w_c = r_work[2];
    assign w_d = r_work[3];
    assign w_e = r_work[4];

    always_comb begin
        if (r_round < 7'd20) begin
            w_f = (w_b & w_c) | (~w_b & w_d);
            w_k = K_PH0;
        end else if (r_round < 7'd40) begin
            w_f = w_b ^ w_c ^ w_d;
            w_k = K_PH1;
        end else if (r_round < 7'd60) begin
            w_f = (w_b & w_c) | (w_b & w_d) | (w_c & w_d);
            w_k = K_PH2;
        end else begin
            w_f = w_b ^ w_c ^ w_d;
            w_k = K_PH3;
        end
    end

    assign w_t = {w_a[26:0], w_a[31:27]} + w_f + w_e + w_k + i_w;

    always_comb begin
        n_work  = r_work;
        n_round = r_round;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_work  = i_chain;
            n_round = '0;
            n_busy  = 1'b1;
        end else if (r_busy) begin
            n_work[0] = w_t;
            n_work[1] = w_a;
            n_work[2] = {w_b[1:0], w_b[31:2]};
            n_work[3] = w_c;
            n_work[4] = w_d;
            n_round   = r_round + 7'd1;
            if (r_round == ROUND_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round <= '0;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_round <= n_round;
            r_busy  <= n_busy;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.step = r_busy;
    assign o_stat.done = r_done;
    assign o_work      = r_work;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("compression started while rounds are running");

    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && (r_round == ROUND_LAST) |=> r_done && !r_busy)
        else $error("final round did not raise done");

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_round <= ROUND_LAST))
        else $error("round counter ran past the last round");

endmodule

// ===== rtl/sha1_byte_stream_hasher.sv =====
// SHA-1 over a byte stream. A byte request that fills a block starts a compression,
// and input stalls until it ends. A closing request shifts in pad and length bytes
// (up to 72), runs one or two compressions, then emits five digest words, one per free
// output cycle. The shared round core runs one SHA-1 round per cycle, 80 per block.
// Synchronous active-low reset: sequencer idle, chain at H0..H4, byte count zero.
// Depends on sha1s_pkg and sha1s_round_core.
module sha1_byte_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_end_of_message,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import sha1s_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PAD  = 5'b00010,
        S_LEN  = 5'b00100,
        S_COMP = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state      r_state;
    t_state      n_state;
    t_state      r_ret;
    t_state      n_ret;
    t_chain      r_chain;
    t_chain      n_chain;
    logic [63:0] r_count;
    logic [63:0] n_count;
    logic [5:0]  r_fill;
    logic [5:0]  n_fill;
    logic        r_pad_first;
    logic        n_pad_first;
    logic [2:0]  r_len_idx;
    logic [2:0]  n_len_idx;
    logic [2:0]  r_oidx;
    logic [2:0]  n_oidx;
    logic        r_out_valid;
    logic        n_out_valid;
    logic [511:0] r_blk;
    logic [31:0] r_out_word;
    logic [2:0]  r_out_idx;
    logic        r_out_last;

    logic        w_byte_shift;
    logic [7:0]  w_shift_byte;
    logic        w_cmp_start;
    logic        w_out_load;
    logic        w_out_free;
    logic [5:0]  w_fill_inc;
    logic [63:0] w_bits;
    t_word       w_next_w;
    t_cmp_stat   w_cmp_stat;
    t_chain      w_work;

    assign w_fill_inc = r_fill + 6'd1;
    assign w_bits     = {r_count[60:0], 3'b000};
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Schedule expansion over the block register: the top word is W[t].
    assign w_next_w = r_blk[511-13*32 -: 32] ^ r_blk[511-8*32 -: 32] ^
                      r_blk[511-2*32 -: 32] ^ r_blk[511:480];

    sha1s_round_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cmp_start),
        .i_chain (r_chain),
        .i_w     (r_blk[511:480]),
        .o_stat  (w_cmp_stat),
        .o_work  (w_work)
    );

    always_comb begin
        n_state      = r_state;
        n_ret        = r_ret;
        n_chain      = r_chain;
        n_count      = r_count;
        n_fill       = r_fill;
        n_pad_first  = r_pad_first;
        n_len_idx    = r_len_idx;
        n_oidx       = r_oidx;
        n_out_valid  = r_out_valid && i_out_stall;
        w_byte_shift = 1'b0;
        w_shift_byte = i_data_byte;
        w_cmp_start  = 1'b0;
        w_out_load   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_pad_first = 1'b1;
                    if (i_has_byte) begin
                        w_byte_shift = 1'b1;
                        n_fill       = w_fill_inc;
                        n_count      = r_count + 64'd1;
                    end
                    if (i_has_byte && (w_fill_inc == '0)) begin
                        w_cmp_start = 1'b1;
                        n_state     = S_COMP;
                        n_ret       = i_end_of_message ? S_PAD : S_IDLE;
                    end else if (i_end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                w_byte_shift = 1'b1;
                w_shift_byte = r_pad_first ? PAD_BYTE : 8'h00;
                n_pad_first  = 1'b0;
                n_fill       = w_fill_inc;
                if (w_fill_inc == '0) begin
                    w_cmp_start = 1'b1;
                    n_state     = S_COMP;
                    n_ret       = S_PAD;
                end else if (w_fill_inc == FILL_LEN_AT) begin
                    n_state   = S_LEN;
                    n_len_idx = 3'd7;
                end
            end
            S_LEN: begin
                // Bit length goes out most significant byte first.
                w_byte_shift = 1'b1;
                w_shift_byte = w_bits[{r_len_idx, 3'b000} +: 8];
                n_len_idx    = r_len_idx - 3'd1;
                n_fill       = w_fill_inc;
                if (w_fill_inc == '0) begin
                    w_cmp_start = 1'b1;
                    n_state     = S_COMP;
                    n_ret       = S_OUT;
                    n_oidx      = '0;
                end
            end
            S_COMP: begin
                if (w_cmp_stat.done) begin
                    for (int i = 0; i < 5; i++) begin
                        n_chain[i] = r_chain[i] + w_work[i];
                    end
                    n_state = r_ret;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    w_out_load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_oidx      = r_oidx + 3'd1;
                    if (r_oidx == LAST_IDX) begin
                        n_chain = H_INIT;
                        n_count = '0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_chain     <= H_INIT;
            r_count     <= '0;
            r_fill      <= '0;
            r_pad_first <= 1'b0;
            r_len_idx   <= '0;
            r_oidx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_chain     <= n_chain;
            r_count     <= n_count;
            r_fill      <= n_fill;
            r_pad_first <= n_pad_first;
            r_len_idx   <= n_len_idx;
            r_oidx      <= n_oidx;
            r_out_valid <= n_out_valid;
        end
    end

    // Bytes shift in at the bottom; each round shifts out W[t] and appends W[t+16].
    always_ff @(posedge i_clk) begin
        if (w_byte_shift) begin
            r_blk <= {r_blk[503:0], w_shift_byte};
        end else if (w_cmp_stat.step) begin
            r_blk <= {r_blk[479:0], w_next_w[30:0], w_next_w[31]};
        end
        if (w_out_load) begin
            r_out_word <= r_chain[r_oidx];
            r_out_idx  <= r_oidx;
            r_out_last <= (r_oidx == LAST_IDX);
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_digest_word = r_out_word;
    assign o_word_index  = r_out_idx;
    assign o_last_word   = r_out_last;

    a_core_in_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmp_stat.busy |-> (r_state == S_COMP))
        else $error("round core busy outside the compression state");

    a_len_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LEN) |-> (r_fill >= FILL_LEN_AT))
        else $error("length bytes placed before the pad reached its position");

    a_out_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_fill == '0))
        else $error("digest emitted with a partly filled block");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_word) |-> (o_word_index == LAST_IDX))
        else $error("last digest word flagged at the wrong index");

endmodule
